### hw/rtl/vrp_pkg.sv
`timescale 1ns / 1ps

package vrp_pkg;

    // Field widths of the voxel and placement words.
    localparam int LOCAL_W  = 8;
    localparam int COLOR_W  = 8;
    localparam int WORLD_W  = 17;

    // Configuration register widths.
    localparam int ROT_W    = 7;
    localparam int SHIFT_W  = 16;
    localparam int EXTENT_W = 9;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = SHIFT_W;

    // Doubled voxel center about the model center, and the sum before halving.
    localparam int CENTER_W = LOCAL_W + 3;
    localparam int SUM_W    = WORLD_W + 1;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ROTATION = 3'd0,
        CFG_SHIFT_X  = 3'd1,
        CFG_SHIFT_Y  = 3'd2,
        CFG_SHIFT_Z  = 3'd3,
        CFG_EXTENT_X = 3'd4,
        CFG_EXTENT_Y = 3'd5,
        CFG_EXTENT_Z = 3'd6
    } t_cfg_idx;

endpackage

### hw/rtl/vrp_voxel_if.sv
`timescale 1ns / 1ps

interface vrp_voxel_if;
    import vrp_pkg::*;

    logic               valid;
    logic               ready;
    logic [LOCAL_W-1:0] local_x;
    logic [LOCAL_W-1:0] local_y;
    logic [LOCAL_W-1:0] local_z;
    logic [COLOR_W-1:0] color_index;

    modport source (output valid, local_x, local_y, local_z, color_index, input ready);
    modport sink   (input valid, local_x, local_y, local_z, color_index, output ready);
endinterface

### hw/rtl/vrp_place_if.sv
`timescale 1ns / 1ps

interface vrp_place_if;
    import vrp_pkg::*;

    logic                      valid;
    logic                      ready;
    logic signed [WORLD_W-1:0] world_x;
    logic signed [WORLD_W-1:0] world_y;
    logic signed [WORLD_W-1:0] world_z;
    logic [COLOR_W-1:0]        color_out;

    modport source (output valid, world_x, world_y, world_z, color_out, input ready);
    modport sink   (input valid, world_x, world_y, world_z, color_out, output ready);
endinterface

### hw/rtl/voxel_rigid_placement_top.sv
`timescale 1ns / 1ps

// Places voxels of one model into world space, one voxel word per cycle.
// The voxel channel (i_voxel) carries the local position and palette index;
// a word is taken at a clock edge where valid and ready are both high. Words
// with palette index zero are empty voxels and are dropped without a result.
// Every other word yields one placement word on o_place: the rotated,
// translated position converted from Z-up to Y-up, plus the palette index.
// The accepted word is held in the input register, and its placement is then
// presented from the output register.
// Throughput is one word per cycle while o_place.ready stays high. When the
// receiver stalls, the output register holds its word and the input register
// fills; i_voxel.ready falls only when both are full.
// Rotation code, shifts and extents are written through the plain write port
// (i_cfg_we, i_cfg_idx, i_cfg_data); the user must do so only while the block
// is idle, as the block does not enforce it. Index seven is ignored, and an
// invalid rotation code acts as the identity. Synchronous reset empties both
// registers and loads rotation code 4, zero shifts and unit extents.
module voxel_rigid_placement_top (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    vrp_voxel_if.sink                       i_voxel,
    vrp_place_if.source                     o_place,
    input  logic                            i_cfg_we,
    input  logic [vrp_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [vrp_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import vrp_pkg::*;

    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Y = 2'd1;
    localparam logic [1:0] AXIS_Z = 2'd2;
    localparam logic [1:0] AXIS_NONE = 2'd3;

    // Configuration registers.
    logic [ROT_W-1:0]           r_rot;
    logic signed [SHIFT_W-1:0]  r_shift_x, r_shift_y, r_shift_z;
    logic [EXTENT_W-1:0]        r_ext_x, r_ext_y, r_ext_z;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rot     <= ROT_W'(4);
            r_shift_x <= '0;
            r_shift_y <= '0;
            r_shift_z <= '0;
            r_ext_x   <= EXTENT_W'(1);
            r_ext_y   <= EXTENT_W'(1);
            r_ext_z   <= EXTENT_W'(1);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_ROTATION: r_rot     <= i_cfg_data[ROT_W-1:0];
                CFG_SHIFT_X:  r_shift_x <= i_cfg_data;
                CFG_SHIFT_Y:  r_shift_y <= i_cfg_data;
                CFG_SHIFT_Z:  r_shift_z <= i_cfg_data;
                CFG_EXTENT_X: r_ext_x   <= i_cfg_data[EXTENT_W-1:0];
                CFG_EXTENT_Y: r_ext_y   <= i_cfg_data[EXTENT_W-1:0];
                CFG_EXTENT_Z: r_ext_z   <= i_cfg_data[EXTENT_W-1:0];
                default: ;
            endcase
        end
    end

    // Handshake: the output register moves on when empty or taken, and the
    // input register moves on whenever the output register can accept.
    logic r_s1_vld;
    logic r_out_vld;
    logic s1_adv;
    logic in_acc;

    assign s1_adv         = !r_out_vld || o_place.ready;
    assign i_voxel.ready  = !r_s1_vld || s1_adv;
    assign in_acc         = i_voxel.valid && i_voxel.ready;

    // Input register. Empty voxels never enter it.
    logic [LOCAL_W-1:0] r_lx, r_ly, r_lz;
    logic [COLOR_W-1:0] r_color;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (i_voxel.ready) begin
            r_s1_vld <= i_voxel.valid && (i_voxel.color_index != '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_lx    <= i_voxel.local_x;
            r_ly    <= i_voxel.local_y;
            r_lz    <= i_voxel.local_z;
            r_color <= i_voxel.color_index;
        end
    end

    // Doubled center about the model center: 2*local + 1 - extent.
    logic signed [CENTER_W-1:0] cen_x, cen_y, cen_z;

    assign cen_x = $signed({2'b00, r_lx, 1'b1}) - $signed({2'b00, r_ext_x});
    assign cen_y = $signed({2'b00, r_ly, 1'b1}) - $signed({2'b00, r_ext_y});
    assign cen_z = $signed({2'b00, r_lz, 1'b1}) - $signed({2'b00, r_ext_z});

    // Rotation decode. A code naming axis three for a row, or the same axis
    // for both rows, falls back to the identity with no sign flips.
    logic [1:0] ax0_code, ax1_code;
    logic       rot_ok;
    logic [1:0] ax0, ax1, ax2;
    logic [2:0] neg;

    assign ax0_code = r_rot[1:0];
    assign ax1_code = r_rot[3:2];
    assign rot_ok   = (ax0_code != AXIS_NONE) && (ax1_code != AXIS_NONE)
                   && (ax0_code != ax1_code);
    assign ax0      = rot_ok ? ax0_code : AXIS_X;
    assign ax1      = rot_ok ? ax1_code : AXIS_Y;
    assign ax2      = rot_ok ? 2'(AXIS_NONE - ax0_code - ax1_code) : AXIS_Z;
    assign neg      = rot_ok ? r_rot[6:4] : 3'b000;

    function automatic logic signed [CENTER_W-1:0] pick_axis(
        input logic [1:0]                 ax,
        input logic signed [CENTER_W-1:0] cx,
        input logic signed [CENTER_W-1:0] cy,
        input logic signed [CENTER_W-1:0] cz
    );
        logic signed [CENTER_W-1:0] res;
        unique case (ax)
            AXIS_X:  res = cx;
            AXIS_Y:  res = cy;
            AXIS_Z:  res = cz;
            default: res = cx;
        endcase
        return res;
    endfunction

    // One row: signed pick, add twice the shift, then floor-halve by
    // dropping the low bit of the two's complement sum.
    function automatic logic signed [WORLD_W-1:0] place_row(
        input logic signed [CENTER_W-1:0] v,
        input logic                       flip,
        input logic signed [SHIFT_W-1:0]  shift
    );
        logic signed [CENTER_W-1:0] sv;
        logic signed [SUM_W-1:0]    sum;
        sv  = flip ? -v : v;
        sum = $signed({{(SUM_W-CENTER_W){sv[CENTER_W-1]}}, sv})
            + $signed({shift[SHIFT_W-1], shift, 1'b0});
        return sum[SUM_W-1:1];
    endfunction

    logic signed [WORLD_W-1:0] w0, w1, w2;

    assign w0 = place_row(pick_axis(ax0, cen_x, cen_y, cen_z), neg[0], r_shift_x);
    assign w1 = place_row(pick_axis(ax1, cen_x, cen_y, cen_z), neg[1], r_shift_y);
    assign w2 = place_row(pick_axis(ax2, cen_x, cen_y, cen_z), neg[2], r_shift_z);

    // Output register. The Y-up frame takes (w0, w2, -w1 - 1), and -w1 - 1
    // is simply the bitwise complement.
    logic signed [WORLD_W-1:0] r_wx, r_wy, r_wz;
    logic [COLOR_W-1:0]        r_color_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (s1_adv) begin
            r_out_vld <= r_s1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv && r_s1_vld) begin
            r_wx        <= w0;
            r_wy        <= w2;
            r_wz        <= ~w1;
            r_color_out <= r_color;
        end
    end

    assign o_place.valid     = r_out_vld;
    assign o_place.world_x   = r_wx;
    assign o_place.world_y   = r_wy;
    assign o_place.world_z   = r_wz;
    assign o_place.color_out = r_color_out;

    // An empty voxel must never produce a placement word.
    a_no_empty_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld |-> (r_color_out != '0))
        else $error("placement word with palette index zero");

    // With the output register free, the block must take a voxel word.
    a_ready_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_out_vld |-> i_voxel.ready)
        else $error("voxel channel stalled with output register free");

    // A non-empty accepted voxel lands in the input register.
    a_nonempty_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && (i_voxel.color_index != '0)) |=> r_s1_vld)
        else $error("accepted voxel lost before the input register");

    // A voxel held in the input register under a stall stays there.
    a_s1_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_vld && !s1_adv) |=> (r_s1_vld && $stable(r_color)))
        else $error("input register changed during a stall");

    // Reset leaves the output register empty.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !r_out_vld)
        else $error("output register valid after reset");

endmodule

### tb/sv/voxel_rigid_placement_top_tb.sv
`timescale 1ns / 1ps

// Self-checking bench for the voxel placement block. Voxel words are queued by
// the stimulus process and handed to a clocked driver; each nonempty word
// that the block takes is run through a local placement model and the
// predicted placement word is queued. A clocked monitor compares every
// placement word that leaves the block against the oldest prediction.
module voxel_rigid_placement_top_tb;
    import vrp_pkg::*;

    // Index seven is not a register; writes to it must have no effect.
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 3'd7;

    localparam int CLK_HALF     = 6;
    localparam int RESET_CYCLES = 5;
    localparam int MAX_BURST    = 14;
    localparam int LONG_HOLD    = 400;
    // Settling margin, used after the channels fall quiet.
    localparam int SETTLE       = 6;
    localparam int PHASES       = 12;
    localparam int PHASE_WORDS  = 165;

    typedef struct packed {
        logic [LOCAL_W-1:0] local_x;
        logic [LOCAL_W-1:0] local_y;
        logic [LOCAL_W-1:0] local_z;
        logic [COLOR_W-1:0] color_index;
    } t_voxel;

    typedef struct packed {
        logic signed [WORLD_W-1:0] world_x;
        logic signed [WORLD_W-1:0] world_y;
        logic signed [WORLD_W-1:0] world_z;
        logic [COLOR_W-1:0]        color_out;
    } t_placement;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    vrp_voxel_if voxel_bus ();
    vrp_place_if place_bus ();

    voxel_rigid_placement_top u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_voxel    (voxel_bus),
        .o_place    (place_bus),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // Local copy of the register file, as the block should hold it.
    logic [ROT_W-1:0]           rot_code;
    logic signed [SHIFT_W-1:0]  shift_x, shift_y, shift_z;
    logic [EXTENT_W-1:0]        extent_x, extent_y, extent_z;

    t_voxel     pending_voxels[$];
    t_placement expected_places[$];
    t_voxel     next_voxel;
    t_placement want;

    int  words_queued;
    int  words_taken;
    int  fault_count;
    int  send_gap;
    int  stall_gap;
    int  send_odds;
    int  stall_odds;
    bit  quiet_tail;
    bit  hold_go;
    bit  hold_stall;

    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // Placement of one voxel under the current register values. The center is
    // kept doubled so that odd extents stay exact; the signed permutation then
    // picks one center component per row, twice the shift is added and the
    // sum is halved toward minus infinity. The last step turns Z-up into Y-up.
    function automatic t_placement place_voxel(t_voxel v);
        int         centre[3];
        int         shift[3];
        int         row_axis[3];
        bit         row_neg[3];
        int         picked;
        int         sum;
        int         w[3];
        int         flipped;
        logic [1:0] axis0;
        logic [1:0] axis1;
        t_placement p;

        centre[0] = 2 * int'(v.local_x) + 1 - int'(extent_x);
        centre[1] = 2 * int'(v.local_y) + 1 - int'(extent_y);
        centre[2] = 2 * int'(v.local_z) + 1 - int'(extent_z);
        shift[0] = int'(shift_x);
        shift[1] = int'(shift_y);
        shift[2] = int'(shift_z);
        axis0 = rot_code[1:0];
        axis1 = rot_code[3:2];

        // An axis field of three or two rows on the same axis is not a
        // rotation; the block then falls back to the identity, signs unused.
        if (axis0 != 2'd3 && axis1 != 2'd3 && axis0 != axis1) begin
            row_axis[0] = axis0;
            row_axis[1] = axis1;
            row_axis[2] = 3 - axis0 - axis1;
            row_neg[0]  = rot_code[4];
            row_neg[1]  = rot_code[5];
            row_neg[2]  = rot_code[6];
        end else begin
            row_axis = '{0, 1, 2};
            row_neg  = '{1'b0, 1'b0, 1'b0};
        end

        for (int k = 0; k < 3; k++) begin
            picked = centre[row_axis[k]];
            sum    = (row_neg[k] ? -picked : picked) + 2 * shift[k];
            w[k]   = sum >>> 1;
        end

        flipped     = -w[1] - 1;
        p.world_x   = w[0][WORLD_W-1:0];
        p.world_y   = w[2][WORLD_W-1:0];
        p.world_z   = flipped[WORLD_W-1:0];
        p.color_out = v.color_index;
        return p;
    endfunction

    // Voxel driver: offers the next queued word once the current one is
    // taken, with random idle bursts unless the run is in its quiet tail.
    // Every taken word with a nonzero palette index gets a prediction.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            voxel_bus.valid <= 1'b0;
        end else begin
            if (voxel_bus.valid && voxel_bus.ready) begin
                words_taken++;
                if (voxel_bus.color_index != '0) begin
                    expected_places = {expected_places, place_voxel({voxel_bus.local_x,
                        voxel_bus.local_y, voxel_bus.local_z, voxel_bus.color_index})};
                end
            end
            if (!voxel_bus.valid || voxel_bus.ready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    voxel_bus.valid <= 1'b0;
                end else if (pending_voxels.size() != 0) begin
                    next_voxel = pending_voxels.pop_front();
                    voxel_bus.valid       <= 1'b1;
                    voxel_bus.local_x     <= next_voxel.local_x;
                    voxel_bus.local_y     <= next_voxel.local_y;
                    voxel_bus.local_z     <= next_voxel.local_z;
                    voxel_bus.color_index <= next_voxel.color_index;
                    if (!quiet_tail && send_odds != 0 && $urandom_range(1, send_odds) == 1) begin
                        send_gap = $urandom_range(1, MAX_BURST);
                    end
                end else begin
                    voxel_bus.valid <= 1'b0;
                end
            end
        end
    end

    // Placement receiver: ready drops in random bursts, and stays low for the
    // whole of a long hold-off when one is running.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            place_bus.ready <= 1'b0;
        end else if (hold_stall) begin
            place_bus.ready <= 1'b0;
        end else if (stall_gap > 0) begin
            stall_gap--;
            place_bus.ready <= 1'b0;
        end else begin
            place_bus.ready <= 1'b1;
            if (!quiet_tail && stall_odds != 0 && $urandom_range(1, stall_odds) == 1) begin
                stall_gap = $urandom_range(1, MAX_BURST);
            end
        end
    end

    // The long hold-off runs once, in its own process, so that the sender
    // keeps offering words while the block fills and pushes back.
    initial begin
        hold_stall = 1'b0;
        wait (hold_go);
        @(posedge i_clk);
        hold_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge i_clk);
        hold_stall <= 1'b0;
    end

    // Checker: each placement word must match the oldest prediction.
    always @(posedge i_clk) begin
        if (i_rst_n && place_bus.valid && place_bus.ready) begin
            if (expected_places.size() == 0) begin
                $error("placement word with none expected: x %0d y %0d z %0d color %0d",
                       place_bus.world_x, place_bus.world_y, place_bus.world_z,
                       place_bus.color_out);
                fault_count++;
            end else begin
                want = expected_places.pop_front();
                if (place_bus.world_x !== want.world_x) begin
                    $error("world_x: expected %0d, got %0d", want.world_x, place_bus.world_x);
                    fault_count++;
                end
                if (place_bus.world_y !== want.world_y) begin
                    $error("world_y: expected %0d, got %0d", want.world_y, place_bus.world_y);
                    fault_count++;
                end
                if (place_bus.world_z !== want.world_z) begin
                    $error("world_z: expected %0d, got %0d", want.world_z, place_bus.world_z);
                    fault_count++;
                end
                if (place_bus.color_out !== want.color_out) begin
                    $error("color_out: expected %0d, got %0d", want.color_out,
                           place_bus.color_out);
                    fault_count++;
                end
            end
        end
    end

    // One register write; the local register copy follows it at once, which
    // is safe because writes only happen while nothing is in flight.
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        case (idx)
            CFG_ROTATION: rot_code = data[ROT_W-1:0];
            CFG_SHIFT_X:  shift_x  = data;
            CFG_SHIFT_Y:  shift_y  = data;
            CFG_SHIFT_Z:  shift_z  = data;
            CFG_EXTENT_X: extent_x = data[EXTENT_W-1:0];
            CFG_EXTENT_Y: extent_y = data[EXTENT_W-1:0];
            CFG_EXTENT_Z: extent_z = data[EXTENT_W-1:0];
            default: ;
        endcase
    endtask

    task automatic load_setting(logic [ROT_W-1:0] rot,
                                logic [SHIFT_W-1:0] sx, logic [SHIFT_W-1:0] sy,
                                logic [SHIFT_W-1:0] sz,
                                logic [EXTENT_W-1:0] ex, logic [EXTENT_W-1:0] ey,
                                logic [EXTENT_W-1:0] ez);
        write_reg(CFG_ROTATION, CFG_DATA_W'(rot));
        write_reg(CFG_SHIFT_X, sx);
        write_reg(CFG_SHIFT_Y, sy);
        write_reg(CFG_SHIFT_Z, sz);
        write_reg(CFG_EXTENT_X, CFG_DATA_W'(ex));
        write_reg(CFG_EXTENT_Y, CFG_DATA_W'(ey));
        write_reg(CFG_EXTENT_Z, CFG_DATA_W'(ez));
    endtask

    task automatic queue_voxel(logic [LOCAL_W-1:0] x, logic [LOCAL_W-1:0] y,
                               logic [LOCAL_W-1:0] z, logic [COLOR_W-1:0] color);
        pending_voxels = {pending_voxels, t_voxel'({x, y, z, color})};
        words_queued++;
    endtask

    // Waits until every queued word has been taken and every placement has
    // come back. Empty voxels leave nothing to wait for, so a few extra cycles
    // let the last of them clear the pipeline.
    task automatic wait_idle();
        while (words_taken != words_queued || expected_places.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE) @(posedge i_clk);
    endtask

    function automatic logic [LOCAL_W-1:0] pick_local();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            default: return LOCAL_W'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic logic [SHIFT_W-1:0] pick_shift();
        case ($urandom_range(0, 5))
            0:       return 16'h8000;
            1:       return 16'h7fff;
            2:       return '0;
            default: return SHIFT_W'($urandom);
        endcase
    endfunction

    // Extents favor the stated range but also take zero and the values above
    // 256 that the nine-bit register allows.
    function automatic logic [EXTENT_W-1:0] pick_extent();
        case ($urandom_range(0, 7))
            0:       return 9'd1;
            1:       return 9'd256;
            2:       return 9'd0;
            3:       return 9'd511;
            4:       return EXTENT_W'($urandom_range(0, 511));
            default: return EXTENT_W'($urandom_range(1, 256));
        endcase
    endfunction

    task automatic queue_random(int count);
        logic [COLOR_W-1:0] color;
        for (int n = 0; n < count; n++) begin
            // About one word in eight is an empty voxel.
            color = ($urandom_range(0, 7) == 0) ? '0 : COLOR_W'($urandom_range(1, 255));
            queue_voxel(pick_local(), pick_local(), pick_local(), color);
        end
    endtask

    function automatic int pick_odds();
        case ($urandom_range(0, 2))
            0:       return 0;
            1:       return 3;
            default: return 8;
        endcase
    endfunction

    initial begin
        i_rst_n               = 1'b0;
        i_cfg_we              = 1'b0;
        i_cfg_idx             = '0;
        i_cfg_data            = '0;
        voxel_bus.valid       = 1'b0;
        voxel_bus.local_x     = '0;
        voxel_bus.local_y     = '0;
        voxel_bus.local_z     = '0;
        voxel_bus.color_index = '0;
        place_bus.ready       = 1'b0;
        words_queued = 0;
        words_taken  = 0;
        fault_count  = 0;
        send_gap     = 0;
        stall_gap    = 0;
        send_odds    = 4;
        stall_odds   = 4;
        quiet_tail   = 1'b0;
        hold_go      = 1'b0;
        // Register values after reset.
        rot_code = 7'd4;
        shift_x  = '0;
        shift_y  = '0;
        shift_z  = '0;
        extent_x = 9'd1;
        extent_y = 9'd1;
        extent_z = 9'd1;

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset registers: corners of the local cube, an empty voxel and the
        // palette extremes.
        queue_voxel(8'd0, 8'd0, 8'd0, 8'd1);
        queue_voxel(8'd255, 8'd255, 8'd255, 8'd255);
        queue_voxel(8'd7, 8'd3, 8'd9, 8'd0);
        queue_voxel(8'd1, 8'd2, 8'd3, 8'd128);
        wait_idle();

        // A true rotation with every row negated, extreme shifts and extents of 256.
        load_setting(7'b1110010, 16'h7fff, 16'h8000, 16'h7fff, 9'd256, 9'd256, 9'd256);
        queue_voxel(8'd0, 8'd0, 8'd0, 8'd255);
        queue_voxel(8'd255, 8'd255, 8'd255, 8'd1);
        queue_voxel(8'd128, 8'd0, 8'd255, 8'd5);
        wait_idle();

        // An axis field of three is not a rotation, so the signs must be
        // ignored. Zero and oversized extents ride along, and a write to the
        // spare index must leave the registers alone.
        load_setting(7'b1110011, 16'h8000, 16'h8000, 16'h8000, 9'd0, 9'd511, 9'd0);
        write_reg(CFG_SPARE, 16'hffff);
        queue_voxel(8'd255, 8'd0, 8'd255, 8'd77);
        queue_voxel(8'd0, 8'd255, 8'd0, 8'd200);
        queue_voxel(8'd0, 8'd0, 8'd0, 8'd0);
        wait_idle();

        // Both rows on the same axis: identity again, with odd extents.
        load_setting(7'b1010101, 16'h7fff, 16'h0001, 16'hffff, 9'd511, 9'd3, 9'd255);
        queue_voxel(8'd255, 8'd255, 8'd0, 8'd9);
        queue_voxel(8'd1, 8'd0, 8'd254, 8'd33);
        queue_voxel(8'd170, 8'd85, 8'd170, 8'd85);
        wait_idle();

        // Random settings, each followed by a burst of random voxels. The
        // third phase runs the long receiver hold-off; the last one runs with
        // no idling on either side.
        for (int phase = 0; phase < PHASES; phase++) begin
            load_setting(ROT_W'($urandom_range(0, 127)), pick_shift(), pick_shift(),
                         pick_shift(), pick_extent(), pick_extent(), pick_extent());
            send_odds  = pick_odds();
            stall_odds = pick_odds();
            if (phase == 2) begin
                hold_go = 1'b1;
            end
            if (phase == PHASES - 1) begin
                quiet_tail = 1'b1;
            end
            queue_random(PHASE_WORDS);
            wait_idle();
        end

        repeat (SETTLE) @(posedge i_clk);
        if (fault_count == 0 && expected_places.size() == 0) begin
            $display("voxel_rigid_placement_top_tb: clean");
        end else begin
            $display("voxel_rigid_placement_top_tb: errors");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run of this stimulus.
    initial begin
        #10_000_000;
        $display("voxel_rigid_placement_top_tb: errors");
        $finish;
    end

endmodule

### filelist.f
hw/rtl/vrp_pkg.sv
hw/rtl/vrp_voxel_if.sv
hw/rtl/vrp_place_if.sv
hw/rtl/voxel_rigid_placement_top.sv
tb/sv/voxel_rigid_placement_top_tb.sv
